[hdl/smf_pkg.sv]
package smf_pkg;

    localparam int PATTERN_MAX_DEFAULT   = 16;
    localparam int POSITION_BITS_DEFAULT = 16;

    localparam int PATTERN_SLOTS = 16;
    localparam int LEN_BITS      = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int POS_OUT_BITS  = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CASE_SENSITIVE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 2'd3;

    typedef logic [PATTERN_SLOTS-1:0][7:0] smf_pattern_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic                case_sensitive;
    } smf_match_cfg_t;

    // ASCII upper case to lower case, everything else unchanged
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            fold_byte = c + 8'h20;
        end else begin
            fold_byte = c;
        end
    endfunction

endpackage

[hdl/smf_cell.sv]
module smf_cell
    import smf_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic           aclk,
    input  logic           shift_en,
    input  logic [7:0]     byte_in,
    output logic [7:0]     byte_out,
    input  smf_pattern_t   pattern,
    input  smf_match_cfg_t cfg,
    output logic           hit
);

    logic [7:0]          byte_reg;
    logic                active;
    logic [LEN_BITS-1:0] pat_idx;
    logic [7:0]          pat_byte;
    logic [7:0]          t_cmp;
    logic [7:0]          p_cmp;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // this cell sees the byte CELL_INDEX places back on byte_in, paired with
    // pattern byte len-1-CELL_INDEX; compare against that incoming byte
    assign active   = LEN_BITS'(CELL_INDEX) < cfg.len;
    assign pat_idx  = cfg.len - LEN_BITS'(CELL_INDEX) - LEN_BITS'(1);
    assign pat_byte = pattern[pat_idx[3:0]];

    always_comb begin
        if (cfg.case_sensitive) begin
            t_cmp = byte_in;
            p_cmp = pat_byte;
        end else begin
            t_cmp = fold_byte(byte_in);
            p_cmp = fold_byte(pat_byte);
        end
    end

    assign hit = !active || (t_cmp == p_cmp);

endmodule

[hdl/substring_first_match.sv]
// substring_first_match: first-occurrence search of a pattern in a byte stream.
// Throughput: one text byte per cycle, held off while an earlier result waits untaken;
// all window cells compare as the byte is accepted. The result is captured in the
// output register as the byte marked tlast is accepted, and holds until taken.
// Reset (aresetn low, synchronous): pattern length 0, case sensitive, pattern
// zero, message state and output valid cleared.
module substring_first_match
    import smf_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] text_byte
    input  logic                     s_tlast,   // last_byte

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata    // [0] found, [16:1] match_position,
                                                // [17] too_long, [23:18] zero
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam int EXT_BITS = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS : POS_OUT_BITS;

    // configuration
    logic [LEN_BITS-1:0] len_reg;
    logic                case_sens_reg;
    smf_pattern_t        pattern_reg;
    smf_match_cfg_t      match_cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            case_sens_reg <= 1'b1;
            pattern_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: len_reg <= cfg_wdata[LEN_BITS-1:0];
                REG_CASE_SENSITIVE: case_sens_reg <= cfg_wdata[0];
                REG_PATTERN_LOW:    pattern_reg[7:0] <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_reg[15:8] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign match_cfg.len            = len_reg;
    assign match_cfg.case_sensitive = case_sens_reg;

    // handshake
    logic s_fire;
    logic m_valid_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // message state
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     have_reg, have_next;
    logic [POSITION_BITS-1:0] first_pos_reg, first_pos_next;
    logic                     ovf_reg, ovf_next;

    logic                     saturated;
    logic                     shift_en;
    logic [POSITION_BITS-1:0] count_inc;
    logic                     match_now;
    logic                     len_ok;

    logic [PATTERN_MAX-1:0]      hits;
    logic [PATTERN_MAX:0][7:0]   chain;

    assign saturated = (count_reg == POS_MAX);
    assign shift_en  = s_fire && !saturated;
    assign count_inc = count_reg + POSITION_BITS'(1);
    assign chain[0]  = s_tdata;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            smf_cell #(
                .CELL_INDEX(k)
            ) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .byte_in  (chain[k]),
                .byte_out (chain[k+1]),
                .pattern  (pattern_reg),
                .cfg      (match_cfg),
                .hit      (hits[k])
            );
        end
    endgenerate

    assign len_ok = (len_reg != '0)
                 && ({1'b0, len_reg} <= (LEN_BITS+1)'(PATTERN_MAX))
                 && (count_inc >= POSITION_BITS'(len_reg));

    assign match_now = !saturated && !have_reg && len_ok && (&hits);

    // result register
    logic                    res_found_reg, res_found_next;
    logic [POS_OUT_BITS-1:0] res_pos_reg, res_pos_next;
    logic                    res_ovf_reg, res_ovf_next;
    logic                    m_valid_next;
    logic                    found_c;
    logic [POSITION_BITS-1:0] pos_c;
    logic [EXT_BITS-1:0]     pos_ext;

    always_comb begin
        count_next     = count_reg;
        have_next      = have_reg;
        first_pos_next = first_pos_reg;
        ovf_next       = ovf_reg;
        found_c        = have_reg;
        pos_c          = first_pos_reg;

        if (match_now) begin
            found_c = 1'b1;
            pos_c   = count_inc - POSITION_BITS'(len_reg);
        end

        if (s_fire) begin
            if (s_tlast) begin
                count_next     = '0;
                have_next      = 1'b0;
                first_pos_next = '0;
                ovf_next       = 1'b0;
            end else begin
                if (saturated) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_inc;
                end
                have_next      = found_c;
                first_pos_next = pos_c;
            end
        end
    end

    assign pos_ext = found_c ? EXT_BITS'(pos_c) : '0;

    always_comb begin
        m_valid_next   = m_valid_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_ovf_next   = res_ovf_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire && s_tlast) begin
            m_valid_next   = 1'b1;
            res_found_next = found_c;
            res_pos_next   = pos_ext[POS_OUT_BITS-1:0];
            res_ovf_next   = ovf_reg || saturated;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            have_reg      <= 1'b0;
            first_pos_reg <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            have_reg      <= have_next;
            first_pos_reg <= first_pos_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_ovf_reg, res_pos_reg, res_found_reg};

endmodule

[verif/tb_substring_first_match.sv]
module tb_substring_first_match;
    import smf_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 400;

    class match_scoreboard;
        typedef struct packed {
            logic        found;
            logic [15:0] pos;
            logic        too_long;
        } search_result_t;

        int            pat_len;
        logic          exact;
        smf_pattern_t  pattern;
        logic [7:0]    window [PATTERN_SLOTS];
        int            count;
        logic          have_match;
        logic [15:0]   first_pos;
        logic          overflowed;
        search_result_t pending_q [$];
        int            errors;
        int            checked;
        int            found_seen;
        int            long_seen;

        function new();
            pat_len    = 0;
            exact      = 1'b1;
            pattern    = '0;
            errors     = 0;
            checked    = 0;
            found_seen = 0;
            long_seen  = 0;
            clear_message();
        endfunction

        function void clear_message();
            foreach (window[k]) window[k] = '0;
            count      = 0;
            have_match = 1'b0;
            first_pos  = '0;
            overflowed = 1'b0;
        endfunction

        function void set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_PATTERN_LENGTH: pat_len = int'(data[LEN_BITS-1:0]);
                REG_CASE_SENSITIVE: exact = data[0];
                REG_PATTERN_LOW:    pattern[7:0] = data;
                REG_PATTERN_HIGH:   pattern[15:8] = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] lower_ascii(input logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
            return c;
        endfunction

        // window[0] is the newest byte, so pattern byte j sits at window[n-1-j]
        function logic window_hits(input int n);
            logic [7:0] t;
            logic [7:0] p;
            for (int j = 0; j < n; j++) begin
                t = window[n - 1 - j];
                p = pattern[j];
                if (!exact) begin
                    t = lower_ascii(t);
                    p = lower_ascii(p);
                end
                if (t != p) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            search_result_t r;
            if (count >= (1 << POSITION_BITS_DEFAULT) - 1) begin
                overflowed = 1'b1;
            end else begin
                for (int k = PATTERN_SLOTS - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = b;
                count++;
                if (!have_match && pat_len != 0 && pat_len <= PATTERN_MAX_DEFAULT &&
                    count >= pat_len && window_hits(pat_len)) begin
                    have_match = 1'b1;
                    first_pos  = 16'(count - pat_len);
                end
            end
            if (last) begin
                r.found    = have_match;
                r.pos      = have_match ? first_pos : 16'd0;
                r.too_long = overflowed;
                pending_q.push_back(r);
                clear_message();
            end
        endfunction

        function void check_result(input logic [23:0] d);
            search_result_t want;
            if (pending_q.size() == 0) begin
                $error("unexpected result transaction, tdata=%h", d);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (d[0] !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, d[0]);
                errors++;
            end
            if (d[16:1] !== want.pos) begin
                $error("match_position: expected %0d, got %0d", want.pos, d[16:1]);
                errors++;
            end
            if (d[17] !== want.too_long) begin
                $error("too_long: expected %0d, got %0d", want.too_long, d[17]);
                errors++;
            end
            if (want.found) found_seen++;
            if (want.too_long) long_seen++;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata   = '0;   // [7:0] text_byte
    logic                     s_tlast   = 1'b0; // last_byte
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [23:0]              m_tdata;          // [0] found, [16:1] match_position,
                                                // [17] too_long

    match_scoreboard sb;
    int tx_idle    = 0;
    int rx_idle    = 0;
    int hold_req   = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int bytes_sent = 0;
    int cycles     = 0;

    substring_first_match u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random backpressure, plus a long hold when the stimulus asks for one
    always @(negedge aclk) begin
        if (hold_req != hold_taken) begin
            hold_taken <= hold_req;
            hold_left  <= HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= (int'($urandom_range(99)) >= rx_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.set_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic program_search(input logic [63:0] len_w, input logic [63:0] cs_w,
                                  input logic [63:0] lo, input logic [63:0] hi);
        write_reg(REG_PATTERN_LENGTH, len_w);
        write_reg(REG_CASE_SENSITIVE, cs_w);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle > 0 && int'($urandom_range(99)) < tx_idle) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_msg(input logic [7:0] msg [$]);
        for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // let every pending result come back, then settle before touching config
    task automatic drain(input int settle);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] edge_char();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h40;
            3: return 8'h5B;
            4: return 8'h60;
            default: return 8'h7B;
        endcase
    endfunction

    function automatic logic [7:0] pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 8'h41 + 8'($urandom_range(25));
        if (r < 60) return 8'h61 + 8'($urandom_range(25));
        if (r < 75) return edge_char();
        return 8'($urandom);
    endfunction

    // flip letter case: often when folding is on, rarely when exact (breaks the match)
    function automatic logic [7:0] case_variant(input logic [7:0] c);
        logic is_letter;
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        if (is_letter && $urandom_range(sb.exact ? 15 : 1) == 0) return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(99);
        if (r < 40) return case_variant(sb.pattern[$urandom_range(15)]);
        if (r < 50) return edge_char();
        return 8'($urandom);
    endfunction

    task automatic random_config(input int g);
        logic [63:0] lw;
        logic [63:0] cw;
        logic [63:0] lo;
        logic [63:0] hi;
        int pick;
        lw   = {$urandom, $urandom};
        cw   = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (g == 0)         lw[4:0] = 5'd16;
        else if (g == 1)    lw[4:0] = 5'd1;
        else if (pick < 10) lw[4:0] = 5'd0;
        else if (pick < 20) lw[4:0] = 5'd16;
        else if (pick < 30) lw[4:0] = 5'($urandom_range(31, 17));
        else                lw[4:0] = 5'($urandom_range(15, 2));
        for (int j = 0; j < 8; j++) begin
            lo[j*8 +: 8] = pattern_char();
            hi[j*8 +: 8] = pattern_char();
        end
        program_search(lw, cw, lo, hi);
    endtask

    task automatic random_msg(input int max_len);
        logic [7:0] msg [$];
        int n;
        int plen;
        int cut;
        int at;
        int r;
        n    = $urandom_range(max_len, 1);
        plen = (sb.pat_len > PATTERN_SLOTS) ? PATTERN_SLOTS : sb.pat_len;
        for (int i = 0; i < n; i++) msg.push_back(text_char());
        r = $urandom_range(99);
        if (plen > 0 && r < 70) begin
            // mostly the whole pattern, sometimes one byte short of it
            cut = (r < 15) ? plen - 1 : plen;
            while (msg.size() < cut) msg.push_back(text_char());
            for (int rep = 0; rep < 2; rep++) begin
                if (rep == 0 || $urandom_range(3) == 0) begin
                    at = $urandom_range(msg.size() - cut, 0);
                    for (int j = 0; j < cut; j++) msg[at + j] = case_variant(sb.pattern[j]);
                end
            end
        end
        send_msg(msg);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int goal,
                             input logic pressure);
        int start;
        int g;
        logic quiet;
        start = bytes_sent;
        g     = 0;
        while (bytes_sent - start < goal) begin
            drain(3);
            random_config(g);
            @(posedge aclk);
            quiet   = ($urandom_range(3) == 0);
            tx_idle = quiet ? 0 : tx_pct;
            rx_idle = quiet ? 0 : rx_pct;
            if (pressure && g == 0) hold_req = hold_req + 1;
            @(negedge aclk);
            if (pressure && g == 0) begin
                for (int m = 0; m < 24; m++) random_msg(3);
            end else begin
                for (int m = 0; m < 8; m++) random_msg(30);
            end
            g++;
        end
    endtask

    // filler digits with the pattern (case flipped) placed at 'at'
    task automatic send_long(input int n, input int at);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            if (i >= at && i < at + 4) b = sb.pattern[i - at] ^ 8'h20;
            else                       b = 8'h30 + 8'(i % 10);
            send_byte(b, i == n - 1);
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset config: empty pattern never matches
        send_msg('{8'h61, 8'h62});
        drain(3);
        program_search(64'd3, 64'd1, 64'h0000_0000_0063_4261, 64'hFFFF_FFFF_FFFF_FFFF);
        send_msg('{8'h78, 8'h61, 8'h42, 8'h63});
        send_msg('{8'h61, 8'h62, 8'h63});
        send_msg('{8'h61, 8'h42});          // shorter than the pattern
        drain(3);
        // '@' and '`' are just outside the folded range
        write_reg(REG_CASE_SENSITIVE, 64'd0);
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        write_reg(REG_PATTERN_LOW, 64'h40);
        cfg_wr_en = 1'b0;
        send_msg('{8'h60, 8'h40});
        drain(3);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_reg(REG_PATTERN_LOW, 64'h5A00);
        cfg_wr_en = 1'b0;
        send_msg('{8'h00, 8'h7A});
        drain(3);
        program_search(64'd1, 64'd1, 64'hFF, 64'h0);
        send_msg('{8'hFF});
        drain(3);
        // length field masks to 31, beyond the maximum pattern
        write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_wr_en = 1'b0;
        send_msg('{8'hFF, 8'hFF});

        run_phase(13, 71, 630, 1'b0);
        run_phase(71, 13, 630, 1'b0);
        run_phase(0, 0, 630, 1'b1);

        drain(3);
        @(posedge aclk);
        tx_idle = 0;
        rx_idle = 0;
        @(negedge aclk);
        program_search(64'd4, 64'd0, 64'h0000_0000_7A59_7857, {$urandom, $urandom});
        send_long(65535, 65531);            // last searchable window
        send_long(65537, 65532);            // match would need an unsearched byte
        send_long(65536, 10);               // early match survives saturation

        drain(8);
        $display("Checked %0d results from %0d text bytes; %0d had a match, %0d saturated.",
                 sb.checked, bytes_sent, sb.found_seen, sb.long_seen);
        $display("Pattern lengths 0 to 31, both compare modes, long backpressure hold.");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
